>>> rtl/canoise_pkg.sv
// Shared types, constants and the sine table of the chaotic attractor noise generator.
// Used by canoise_ctrl, canoise_dp and the top level; depends on nothing.
package canoise_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int SINE_DEPTH = 1024;
    localparam int IDX_W      = $clog2(SINE_DEPTH);
    localparam int SIN_W      = FRAC_BITS + 2;
    localparam int ACC_W      = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 16;

    localparam logic signed [31:0] INV_TWO_PI = 32'sd683565276;
    localparam logic signed [31:0] ONE_Q      = 32'sd1 <<< FRAC_BITS;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    localparam longint unsigned RST_A_W = ((64'd2871 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam longint unsigned RST_B_W = (64'd11 << FRAC_BITS) / 64'd4;
    localparam longint unsigned RST_C_W = 64'd1 << FRAC_BITS;
    localparam longint unsigned RST_D_W = (64'd3 << FRAC_BITS) / 64'd4;
    localparam longint unsigned RST_S_W = 64'd1 << (FRAC_BITS - 1);

    localparam logic [15:0] RST_COEF_A = RST_A_W[15:0];
    localparam logic [15:0] RST_COEF_B = RST_B_W[15:0];
    localparam logic [15:0] RST_COEF_C = RST_C_W[15:0];
    localparam logic [15:0] RST_COEF_D = RST_D_W[15:0];
    localparam logic [15:0] RST_SEED   = RST_S_W[15:0];
    localparam logic [12:0] RST_PAN    = 13'd2048;
    localparam logic [12:0] PAN_FULL   = 13'd4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_Y = 3'd7;

    // multiplier operand selections
    localparam logic [3:0] MS_NONE = 4'd0;
    localparam logic [3:0] MS_BY   = 4'd1;
    localparam logic [3:0] MS_BX   = 4'd2;
    localparam logic [3:0] MS_AX   = 4'd3;
    localparam logic [3:0] MS_AY   = 4'd4;
    localparam logic [3:0] MS_ARG  = 4'd5;
    localparam logic [3:0] MS_CS   = 4'd6;
    localparam logic [3:0] MS_DS   = 4'd7;
    localparam logic [3:0] MS_XK   = 4'd8;
    localparam logic [3:0] MS_GAIN = 4'd9;
    localparam logic [3:0] MS_PL   = 4'd10;
    localparam logic [3:0] MS_PR   = 4'd11;

    // accumulator operations
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_SET  = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    // sample source
    localparam logic [1:0] SMP_HOLD = 2'd0;
    localparam logic [1:0] SMP_X    = 2'd1;
    localparam logic [1:0] SMP_SIN  = 2'd2;

    typedef struct packed {
        logic       start;
        logic [3:0] mul_sel;
        logic       rom_en;
        logic [1:0] nx_op;
        logic [1:0] ny_op;
        logic       commit;
        logic [1:0] samp_op;
        logic       base_ld;
        logic       left_ld;
        logic       right_ld;
        logic       out_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic wrap;
        logic out_busy;
    } dp_stat_t;

    typedef logic signed [15:0] sine_rom_t [SINE_DEPTH];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint m;
        longint v;
        longint unsigned mag;
        longint unsigned th;
        longint unsigned t2;
        longint unsigned r;
        longint unsigned s;
        longint unsigned e;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            m = 4 * longint'(k);
            if (m <= SINE_DEPTH)
                v = m;
            else if (m <= 3 * SINE_DEPTH)
                v = 2 * SINE_DEPTH - m;
            else
                v = m - 4 * SINE_DEPTH;
            mag = (v < 0) ? longint'(-v) : longint'(v);
            th  = mag * HALF_PI_Q30 / SINE_DEPTH;
            t2  = (th * th) >> 30;
            r   = ONE_Q30 - t2 / 110;
            r   = ONE_Q30 - ((t2 * r) >> 30) / 72;
            r   = ONE_Q30 - ((t2 * r) >> 30) / 42;
            r   = ONE_Q30 - ((t2 * r) >> 30) / 20;
            r   = ONE_Q30 - ((t2 * r) >> 30) / 6;
            s   = (th * r) >> 30;
            e   = (s + (64'd1 << 14)) >> 15;
            if (e > 32767)
                e = 32767;
            rom[k] = (v < 0) ? -$signed(e[15:0]) : $signed(e[15:0]);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] res;
        if (v > 64'sd32767)
            res = 16'sh7fff;
        else if (v < -64'sd32768)
            res = -16'sh8000;
        else
            res = v[15:0];
        return res;
    endfunction

endpackage

>>> rtl/chaotic_attractor_noise_generator.sv
// Top level of the chaotic attractor noise generator (Latoocarfian map, Q4.12).
// Instantiates canoise_ctrl and canoise_dp; depends on canoise_pkg.
//
//  channel   direction  handshake                    contents
//  s_axis    in         tvalid/tready                tdata[0] restart
//  m_axis    out        tvalid/tready                tdata left, right sample
//  cfg       in         cfg_we (no back-pressure)    cfg_index, cfg_data
//
// When the new x leaves -1..1, its sine is taken as the sample; all products go
// through one shared 32x32 multiplier, one at a time.
// A finished pair waits in the output register while the next request runs.
// Reset clears the sequencer and loads register and orbit defaults at once.
module chaotic_attractor_noise_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // [0] restart
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [31:0]                          m_axis_tdata,  // [15:0] left, [31:16] right
    input  logic                                 cfg_we,
    input  logic [canoise_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [canoise_pkg::CFG_W-1:0]        cfg_data
);
    import canoise_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;

    canoise_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    canoise_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .restart      (s_axis_tdata[0]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .cmd          (cmd),
        .stat         (stat)
    );

    assign m_axis_tdata = {right_sample, left_sample};

endmodule

>>> rtl/canoise_ctrl.sv
// Sequencer of the chaotic attractor noise generator: steps the shared multiplier,
// sine table and accumulators through one map iteration. Depends on canoise_pkg.
module canoise_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  canoise_pkg::dp_stat_t stat,
    output canoise_pkg::dp_cmd_t  cmd
);
    import canoise_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_BY   = 5'd1;
    localparam logic [4:0] ST_BYA  = 5'd2;
    localparam logic [4:0] ST_BYR  = 5'd3;
    localparam logic [4:0] ST_BX   = 5'd4;
    localparam logic [4:0] ST_BXA  = 5'd5;
    localparam logic [4:0] ST_BXR  = 5'd6;
    localparam logic [4:0] ST_CS   = 5'd7;
    localparam logic [4:0] ST_AX   = 5'd8;
    localparam logic [4:0] ST_AXA  = 5'd9;
    localparam logic [4:0] ST_AXR  = 5'd10;
    localparam logic [4:0] ST_AY   = 5'd11;
    localparam logic [4:0] ST_AYA  = 5'd12;
    localparam logic [4:0] ST_AYR  = 5'd13;
    localparam logic [4:0] ST_DS   = 5'd14;
    localparam logic [4:0] ST_NYA  = 5'd15;
    localparam logic [4:0] ST_CMT  = 5'd16;
    localparam logic [4:0] ST_CHK  = 5'd17;
    localparam logic [4:0] ST_SR   = 5'd18;
    localparam logic [4:0] ST_SS   = 5'd19;
    localparam logic [4:0] ST_GN   = 5'd20;
    localparam logic [4:0] ST_BS   = 5'd21;
    localparam logic [4:0] ST_PL   = 5'd22;
    localparam logic [4:0] ST_PR   = 5'd23;
    localparam logic [4:0] ST_RT   = 5'd24;
    localparam logic [4:0] ST_OUT  = 5'd25;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_BY;
                end
            end
            ST_BY:
            begin
                cmd.mul_sel = MS_BY;
                state_next  = ST_BYA;
            end
            ST_BYA:
            begin
                cmd.mul_sel = MS_ARG;
                state_next  = ST_BYR;
            end
            ST_BYR:
            begin
                cmd.rom_en = 1'b1;
                state_next = ST_BX;
            end
            ST_BX:
            begin
                cmd.nx_op   = ACC_SET;
                cmd.mul_sel = MS_BX;
                state_next  = ST_BXA;
            end
            ST_BXA:
            begin
                cmd.mul_sel = MS_ARG;
                state_next  = ST_BXR;
            end
            ST_BXR:
            begin
                cmd.rom_en = 1'b1;
                state_next = ST_CS;
            end
            ST_CS:
            begin
                cmd.mul_sel = MS_CS;
                state_next  = ST_AX;
            end
            ST_AX:
            begin
                cmd.nx_op   = ACC_ADD;
                cmd.mul_sel = MS_AX;
                state_next  = ST_AXA;
            end
            ST_AXA:
            begin
                cmd.mul_sel = MS_ARG;
                state_next  = ST_AXR;
            end
            ST_AXR:
            begin
                cmd.rom_en = 1'b1;
                state_next = ST_AY;
            end
            ST_AY:
            begin
                cmd.ny_op   = ACC_SET;
                cmd.mul_sel = MS_AY;
                state_next  = ST_AYA;
            end
            ST_AYA:
            begin
                cmd.mul_sel = MS_ARG;
                state_next  = ST_AYR;
            end
            ST_AYR:
            begin
                cmd.rom_en = 1'b1;
                state_next = ST_DS;
            end
            ST_DS:
            begin
                cmd.mul_sel = MS_DS;
                state_next  = ST_NYA;
            end
            ST_NYA:
            begin
                cmd.ny_op  = ACC_ADD;
                state_next = ST_CMT;
            end
            ST_CMT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (stat.wrap)
                begin
                    cmd.mul_sel = MS_XK;
                    state_next  = ST_SR;
                end
                else
                begin
                    cmd.samp_op = SMP_X;
                    state_next  = ST_GN;
                end
            end
            ST_SR:
            begin
                cmd.rom_en = 1'b1;
                state_next = ST_SS;
            end
            ST_SS:
            begin
                cmd.samp_op = SMP_SIN;
                state_next  = ST_GN;
            end
            ST_GN:
            begin
                cmd.mul_sel = MS_GAIN;
                state_next  = ST_BS;
            end
            ST_BS:
            begin
                cmd.base_ld = 1'b1;
                state_next  = ST_PL;
            end
            ST_PL:
            begin
                cmd.mul_sel = MS_PL;
                state_next  = ST_PR;
            end
            ST_PR:
            begin
                cmd.mul_sel = MS_PR;
                cmd.left_ld = 1'b1;
                state_next  = ST_RT;
            end
            ST_RT:
            begin
                cmd.right_ld = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/canoise_dp.sv
// Datapath of the chaotic attractor noise generator: registers, shared multiplier,
// sine table, accumulators and output register. Depends on canoise_pkg.
module canoise_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [canoise_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [canoise_pkg::CFG_W-1:0]        cfg_data,
    input  logic                                 restart,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [15:0]                   left_sample,
    output logic signed [15:0]                   right_sample,
    input  canoise_pkg::dp_cmd_t                 cmd,
    output canoise_pkg::dp_stat_t                stat
);
    import canoise_pkg::*;

    logic signed [15:0]      coef_a_reg;
    logic signed [15:0]      coef_b_reg;
    logic signed [15:0]      coef_c_reg;
    logic signed [15:0]      coef_d_reg;
    logic [14:0]             gain_reg;
    logic [12:0]             pan_reg;
    logic signed [15:0]      seed_x_reg;
    logic signed [15:0]      seed_y_reg;

    logic signed [15:0]      x_reg;
    logic signed [15:0]      y_reg;
    logic signed [63:0]      p_reg;
    logic signed [63:0]      p_next;
    logic signed [SIN_W-1:0] sin_reg;
    logic signed [SIN_W-1:0] sin_next;
    logic signed [ACC_W-1:0] nx_reg;
    logic signed [ACC_W-1:0] ny_reg;
    logic signed [15:0]      samp_reg;
    logic signed [31:0]      base_reg;
    logic signed [15:0]      left_reg;
    logic signed [15:0]      right_reg;
    logic                    out_valid_reg;

    logic signed [31:0]      op_a;
    logic signed [31:0]      op_b;
    logic signed [63:0]      p_frac;
    logic signed [63:0]      p_out;
    logic signed [31:0]      arg;
    logic [IDX_W-1:0]        idx;
    logic signed [15+FRAC_BITS:0] rom_sc;
    logic [12:0]             pan_eff;
    logic [12:0]             pan_rest;
    logic signed [31:0]      x_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= RST_COEF_A;
            coef_b_reg <= RST_COEF_B;
            coef_c_reg <= RST_COEF_C;
            coef_d_reg <= RST_COEF_D;
            gain_reg   <= '0;
            pan_reg    <= RST_PAN;
            seed_x_reg <= RST_SEED;
            seed_y_reg <= RST_SEED;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_A: coef_a_reg <= cfg_data;
                CFG_COEF_B: coef_b_reg <= cfg_data;
                CFG_COEF_C: coef_c_reg <= cfg_data;
                CFG_COEF_D: coef_d_reg <= cfg_data;
                CFG_GAIN:   gain_reg   <= cfg_data[14:0];
                CFG_PAN:    pan_reg    <= cfg_data[12:0];
                CFG_SEED_X: seed_x_reg <= cfg_data;
                CFG_SEED_Y: seed_y_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign p_frac   = p_reg >>> FRAC_BITS;
    assign p_out    = p_reg >>> (FRAC_BITS + 12);
    assign arg      = p_frac[31:0];
    assign idx      = p_reg[32+FRAC_BITS-1 -: IDX_W];
    assign pan_eff  = (pan_reg > PAN_FULL) ? PAN_FULL : pan_reg;
    assign pan_rest = PAN_FULL - pan_eff;
    assign x_wide   = 32'(x_reg);

    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_BY:   begin op_a = 32'(coef_b_reg); op_b = 32'(y_reg);    end
            MS_BX:   begin op_a = 32'(coef_b_reg); op_b = 32'(x_reg);    end
            MS_AX:   begin op_a = 32'(coef_a_reg); op_b = 32'(x_reg);    end
            MS_AY:   begin op_a = 32'(coef_a_reg); op_b = 32'(y_reg);    end
            MS_ARG:  begin op_a = arg;             op_b = INV_TWO_PI;    end
            MS_CS:   begin op_a = 32'(coef_c_reg); op_b = 32'(sin_reg);  end
            MS_DS:   begin op_a = 32'(coef_d_reg); op_b = 32'(sin_reg);  end
            MS_XK:   begin op_a = 32'(x_reg);      op_b = INV_TWO_PI;    end
            MS_GAIN: begin op_a = 32'(samp_reg);   op_b = $signed({17'd0, gain_reg}); end
            MS_PL:   begin op_a = base_reg;        op_b = $signed({19'd0, pan_eff});  end
            MS_PR:   begin op_a = base_reg;        op_b = $signed({19'd0, pan_rest}); end
            default: begin op_a = '0;              op_b = '0;            end
        endcase
        p_next   = op_a * op_b;
        rom_sc   = $signed({SINE_ROM[idx], {FRAC_BITS{1'b0}}}) >>> 15;
        sin_next = rom_sc[SIN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_sel != MS_NONE)
            p_reg <= p_next;
        if (cmd.rom_en)
            sin_reg <= sin_next;
        unique case (cmd.nx_op)
            ACC_SET: nx_reg <= ACC_W'(sin_reg);
            ACC_ADD: nx_reg <= nx_reg + p_frac[ACC_W-1:0];
            default: ;
        endcase
        unique case (cmd.ny_op)
            ACC_SET: ny_reg <= ACC_W'(sin_reg);
            ACC_ADD: ny_reg <= ny_reg + p_frac[ACC_W-1:0];
            default: ;
        endcase
        unique case (cmd.samp_op)
            SMP_X:   samp_reg <= x_reg;
            SMP_SIN: samp_reg <= 16'(sin_reg);
            default: ;
        endcase
        if (cmd.base_ld)
            base_reg <= p_reg[31:0];
        if (cmd.left_ld)
            left_reg <= sat16(p_out);
        if (cmd.right_ld)
            right_reg <= sat16(p_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= RST_SEED;
            y_reg <= RST_SEED;
        end
        else if (cmd.start && restart)
        begin
            x_reg <= seed_x_reg;
            y_reg <= seed_y_reg;
        end
        else if (cmd.commit)
        begin
            x_reg <= sat16(64'(nx_reg));
            y_reg <= sat16(64'(ny_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_ld)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            left_sample  <= left_reg;
            right_sample <= right_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign stat.wrap     = (x_wide > ONE_Q) || (x_wide < -ONE_Q);
    assign stat.out_busy = out_valid_reg && !out_ready;

endmodule

>>> sim/chaotic_attractor_noise_generator_check.sv
// Checker for the chaotic attractor noise generator: tracks register writes, predicts
// every stereo sample from the accepted requests and compares the outputs.
// Depends on canoise_pkg for the register indexes only.
module chaotic_attractor_noise_generator_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          samples_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import canoise_pkg::*;

    typedef struct packed {
        logic signed [15:0] right;
        logic signed [15:0] left;
    } stereo_t;

    longint sine_tbl [1024];
    logic signed [15:0] ca, cb, cc, cd, sx, sy;
    logic [14:0] amp;
    logic [12:0] pan;
    longint ox, oy;
    stereo_t want_q [$];

    initial
    begin
        longint v, m;
        longint unsigned mag, th, t2, r, s, e;
        for (int k = 0; k < 1024; k++)
        begin
            m = 4 * k;
            if (m <= 1024)
                v = m;
            else if (m <= 3072)
                v = 2048 - m;
            else
                v = m - 4096;
            mag = (v < 0) ? -v : v;
            th = mag * 64'd1686629713 / 1024;
            t2 = (th * th) >> 30;
            r = (64'd1 << 30) - t2 / 110;
            r = (64'd1 << 30) - ((t2 * r) >> 30) / 72;
            r = (64'd1 << 30) - ((t2 * r) >> 30) / 42;
            r = (64'd1 << 30) - ((t2 * r) >> 30) / 20;
            r = (64'd1 << 30) - ((t2 * r) >> 30) / 6;
            s = (th * r) >> 30;
            e = (s + (64'd1 << 14)) >> 15;
            if (e > 32767)
                e = 32767;
            sine_tbl[k] = (v < 0) ? -longint'(e) : longint'(e);
        end
    end

    function automatic longint sine_of(longint arg);
        longint unsigned prod, frac, idx;
        prod = longint'(arg) * 64'd683565276;
        frac = (prod & ((64'd1 << 44) - 1)) >> 12;
        idx = (frac * 1024) >> 32;
        return sine_tbl[idx] >>> 3;
    endfunction

    function automatic longint clip16(longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic stereo_t next_sample(logic rs);
        longint nx, ny, samp, p, base;
        stereo_t res;
        if (rs)
        begin
            ox = longint'(sx);
            oy = longint'(sy);
        end
        nx = sine_of((cb * oy) >>> 12) + ((cc * sine_of((cb * ox) >>> 12)) >>> 12);
        ny = sine_of((ca * ox) >>> 12) + ((cd * sine_of((ca * oy) >>> 12)) >>> 12);
        ox = clip16(nx);
        oy = clip16(ny);
        samp = (ox > 4096 || ox < -4096) ? sine_of(ox) : ox;
        p = (pan > 4096) ? 4096 : pan;
        base = samp * longint'(amp);
        res.left = 16'(clip16((base * p) >>> 24));
        res.right = 16'(clip16((base * (4096 - p)) >>> 24));
        return res;
    endfunction

    assign pending = want_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        stereo_t got, want;
        if (!rst_n)
        begin
            ca = 16'sd11760;
            cb = 16'sd11264;
            cc = 16'sd4096;
            cd = 16'sd3072;
            amp = '0;
            pan = 13'd2048;
            sx = 16'sd2048;
            sy = 16'sd2048;
            ox = 2048;
            oy = 2048;
            errors = 0;
            samples_seen = 0;
            want_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COEF_A: ca = cfg_data;
                    CFG_COEF_B: cb = cfg_data;
                    CFG_COEF_C: cc = cfg_data;
                    CFG_COEF_D: cd = cfg_data;
                    CFG_GAIN:   amp = cfg_data[14:0];
                    CFG_PAN:    pan = cfg_data[12:0];
                    CFG_SEED_X: sx = cfg_data;
                    CFG_SEED_Y: sy = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                want_q.push_back(next_sample(s_axis_tdata[0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                samples_seen++;
                if (want_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected sample, expected none actual %h", $time, got);
                end
                else
                begin
                    want = want_q.pop_front();
                    if (got.left !== want.left)
                    begin
                        errors++;
                        $display("%0t: left expected %0d actual %0d", $time, want.left, got.left);
                    end
                    if (got.right !== want.right)
                    begin
                        errors++;
                        $display("%0t: right expected %0d actual %0d", $time, want.right,
                                 got.right);
                    end
                end
            end
        end
    end
endmodule

>>> sim/chaotic_attractor_noise_generator_test.sv
// Testbench top: drives requests, register writes and output back-pressure for the
// chaotic attractor noise generator and gives the verdict from the checker's count.
// Depends on canoise_pkg, the block and chaotic_attractor_noise_generator_check.
module chaotic_attractor_noise_generator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import canoise_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          errors, pending, samples_seen;
    bit          calm = 1'b0;
    int          sent = 0;

    always #1 clk = ~clk;

    chaotic_attractor_noise_generator u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    chaotic_attractor_noise_generator_check u_check (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .samples_seen(samples_seen)
    );

    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);

    task automatic send_request(logic rs);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'($urandom), rs};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
        if (!calm && $urandom_range(0, 99) < 44)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 28)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_regs(logic [15:0] vals [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] regs [8];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // defaults, gain still zero
        for (int i = 0; i < 4; i++)
            send_request(i[0]);
        drain();
        for (int ph = 0; ph < 10; ph++)
        begin
            regs = '{16'd11760, 16'd11264, 16'd4096, 16'd3072, 16'h7fff, 16'd4096,
                     16'd2048, 16'd2048};
            case (ph)
                0: ;
                1: regs[CFG_PAN] = 16'd0;
                2:
                begin
                    regs = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'h1fff,
                             16'h7fff, 16'h8000};
                end
                3:
                begin
                    regs = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'd4097,
                             16'h8000, 16'h7fff};
                end
                default:
                begin
                    for (int i = 0; i < 8; i++)
                        regs[i] = 16'($urandom);
                    if (ph % 2 == 0)
                    begin
                        regs[CFG_COEF_A] = 16'($urandom_range(8192, 16384));
                        regs[CFG_COEF_B] = 16'($urandom_range(8192, 16384));
                        regs[CFG_COEF_C] = 16'($urandom_range(2048, 6144));
                        regs[CFG_COEF_D] = 16'($urandom_range(2048, 6144));
                    end
                    regs[CFG_PAN] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(0, 4096));
                end
            endcase
            write_regs(regs);
            calm = (ph == 4);
            if (ph < 4)
            begin
                for (int i = 0; i < 5; i++)
                    send_request(i == 0 || i == 3);
            end
            else
            begin
                for (int i = 0; i < 210; i++)
                    send_request($urandom_range(0, 15) == 0);
            end
            calm = 1'b0;
            drain();
        end
        $display("Sent %0d requests across 11 register settings; %0d samples compared.",
                 sent, samples_seen);
        $display("Covered coefficient, seed, gain and pan extremes, restarts and stalls.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
rtl/canoise_pkg.sv
rtl/canoise_ctrl.sv
rtl/canoise_dp.sv
rtl/chaotic_attractor_noise_generator.sv
sim/chaotic_attractor_noise_generator_check.sv
sim/chaotic_attractor_noise_generator_test.sv
